FILE: sv/test_pattern_pixel_generator_defines.svh
// ----------------------------------------------------------------------------
// Test pattern pixel generator assertion macros
// Concurrent checks that are compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TEST_PATTERN_PIXEL_GENERATOR_DEFINES_SVH
`define TEST_PATTERN_PIXEL_GENERATOR_DEFINES_SVH

`ifndef SYNTH
`define TPPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tppg check failed");
`define TPPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tppg check failed");
`else
`define TPPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TPPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/tppg_pkg.sv
// ----------------------------------------------------------------------------
// Test pattern pixel generator package
// Widths, register indexes and pattern codes shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tppg_pkg;

    localparam int MAX_SIDE = 4096;

    localparam int COORD_W = 12;
    localparam int SIZE_W  = 13;
    localparam int CH_W    = 8;
    localparam int COLOR_W = 24;
    localparam int MODE_W  = 2;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = ADDR_W - 2;

    localparam int Q_W     = COORD_W;
    localparam int NUM_W   = 22;
    localparam int REM_W   = NUM_W;
    localparam int DIVS_W  = SIZE_W + Q_W - 1;
    localparam int NLANE   = 5;
    localparam int NCHAN   = 3;

    localparam logic [MODE_W-1:0] MODE_FLAT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VGRAD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HGRAD = 2'd3;

    localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_COLOR_A = 3'd1;
    localparam logic [IDX_W-1:0] REG_COLOR_B = 3'd2;
    localparam logic [IDX_W-1:0] REG_BLOCK   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SQUARES = 3'd4;
    localparam logic [IDX_W-1:0] REG_SIDE    = 3'd5;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CH_W-1:0]    chan_t;

endpackage

`default_nettype wire

FILE: sv/tppg_in_if.sv
// ----------------------------------------------------------------------------
// Pixel request channel
// Valid/ready channel that carries one pixel coordinate per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tppg_in_if;
    import tppg_pkg::*;

    logic   valid;
    logic   ready;
    coord_t pixel_x;
    coord_t pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

FILE: sv/tppg_out_if.sv
// ----------------------------------------------------------------------------
// Pixel result channel
// Valid/ready channel that carries three colour channels and the outside flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tppg_out_if;
    import tppg_pkg::*;

    logic  valid;
    logic  ready;
    chan_t chan0;
    chan_t chan1;
    chan_t chan2;
    logic  outside;

    modport source (output valid, output chan0, output chan1, output chan2,
                    output outside, input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2,
                    input outside, output ready);
endinterface

`default_nettype wire

FILE: sv/test_pattern_pixel_generator.sv
// An accepted item passes stage A, stage B, the divider stages and the output register.
// Throughput: one item per cycle; a stalled output holds every stage in place.
// The divider is a 12-stage restoring divider, one quotient bit per stage.
// Reset: asynchronous active low; clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// Test pattern pixel generator
// Flat, checkerboard and gradient patterns computed per pixel coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module test_pattern_pixel_generator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tppg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tppg_pkg::DATA_W-1:0] pwdata,
    output logic      [tppg_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    tppg_in_if.sink                          pix_in,
    tppg_out_if.source                       pix_out
);
    import tppg_pkg::*;

`include "test_pattern_pixel_generator_defines.svh"

    localparam int DIV_STAGES = Q_W;
    localparam int SIDE2_W    = 2 * SIZE_W;
    localparam int AS_W       = CH_W + SIZE_W;
    localparam int CD_W       = COORD_W + CH_W + 2;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (int'(v) > MAX_SIDE)
            r = SIZE_W'(MAX_SIDE);
        else
            r = v;
        return r;
    endfunction

    logic [MODE_W-1:0]  mode_reg;
    logic [COLOR_W-1:0] color_a_reg;
    logic [COLOR_W-1:0] color_b_reg;
    logic [SIZE_W-1:0]  block_reg;
    logic [SIZE_W-1:0]  squares_reg;
    logic [SIZE_W-1:0]  side_reg;

    logic             cfg_wr;
    logic [IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_FLAT;
            color_a_reg <= '0;
            color_b_reg <= '1;
            block_reg   <= SIZE_W'(32);
            squares_reg <= SIZE_W'(8);
            side_reg    <= SIZE_W'(256);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MODE:    mode_reg    <= pwdata[MODE_W-1:0];
                REG_COLOR_A: color_a_reg <= pwdata[COLOR_W-1:0];
                REG_COLOR_B: color_b_reg <= pwdata[COLOR_W-1:0];
                REG_BLOCK:   block_reg   <= pwdata[SIZE_W-1:0];
                REG_SQUARES: squares_reg <= pwdata[SIZE_W-1:0];
                REG_SIDE:    side_reg    <= pwdata[SIZE_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MODE:    prdata = DATA_W'(mode_reg);
            REG_COLOR_A: prdata = DATA_W'(color_a_reg);
            REG_COLOR_B: prdata = DATA_W'(color_b_reg);
            REG_BLOCK:   prdata = DATA_W'(block_reg);
            REG_SQUARES: prdata = DATA_W'(squares_reg);
            REG_SIDE:    prdata = DATA_W'(side_reg);
            default:     prdata = '0;
        endcase
    end

    logic [SIZE_W-1:0] bs;
    logic [SIZE_W-1:0] sc;
    logic [SIZE_W-1:0] side;
    logic              is_check;

    assign bs       = clamp_size(block_reg);
    assign sc       = clamp_size(squares_reg);
    assign side     = clamp_size(side_reg);
    assign is_check = (mode_reg == MODE_CHECK);

    logic out_valid_reg;
    logic pipe_en;

    assign pipe_en      = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = pipe_en;

    // Stage A: products
    logic                          a_valid_reg;
    coord_t                        a_x_reg;
    coord_t                        a_y_reg;
    logic [SIDE2_W-1:0]            a_chk_side_reg;
    logic [NCHAN-1:0][AS_W-1:0]    a_as_reg;
    logic signed [CD_W-1:0]        a_cd_reg [NCHAN];

    coord_t ramp_c;
    assign ramp_c = (mode_reg == MODE_VGRAD) ? pix_in.pixel_y : pix_in.pixel_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (pipe_en)
            a_valid_reg <= pix_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_x_reg        <= pix_in.pixel_x;
            a_y_reg        <= pix_in.pixel_y;
            a_chk_side_reg <= bs * sc;
            for (int k = 0; k < NCHAN; k++)
            begin
                a_as_reg[k] <= color_a_reg[CH_W*k +: CH_W] * side;
                a_cd_reg[k] <= $signed(CD_W'(ramp_c))
                               * ($signed(CD_W'(color_a_reg[CH_W*k +: CH_W]))
                                  - $signed(CD_W'(color_b_reg[CH_W*k +: CH_W])));
            end
        end
    end

    // Stage B: bounds and dividends
    logic signed [CD_W:0]    num_s [NCHAN];
    logic [NLANE-1:0][REM_W-1:0] lane_num;
    logic                    b_outside;

    always_comb
    begin
        lane_num[0] = REM_W'(a_x_reg);
        lane_num[1] = REM_W'(a_y_reg);
        for (int k = 0; k < NCHAN; k++)
        begin
            num_s[k] = $signed({2'b00, a_as_reg[k]}) - (CD_W + 1)'(a_cd_reg[k]);
            lane_num[k + 2] = num_s[k][CD_W] ? '0 : REM_W'(num_s[k]);
        end
        if (is_check)
            b_outside = (SIDE2_W'(a_x_reg) >= a_chk_side_reg)
                     || (SIDE2_W'(a_y_reg) >= a_chk_side_reg);
        else
            b_outside = (SIZE_W'(a_x_reg) >= side) || (SIZE_W'(a_y_reg) >= side);
    end

    logic [DIV_STAGES:0]                valid_reg;
    logic                               outside_reg [DIV_STAGES+1];
    logic [NLANE-1:0][REM_W-1:0]        rem_reg [DIV_STAGES+1];
    logic [NLANE-1:0][Q_W-1:0]          quo_reg [DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (pipe_en)
            valid_reg <= {valid_reg[DIV_STAGES-1:0], a_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            outside_reg[0] <= b_outside;
            rem_reg[0]     <= lane_num;
            quo_reg[0]     <= '0;
        end
    end

    // Divider: one quotient bit per stage, most significant first
    for (genvar i = 1; i <= DIV_STAGES; i++)
    begin : g_div
        localparam int K = DIV_STAGES - i;
        logic [NLANE-1:0][REM_W-1:0] rem_next;
        logic [NLANE-1:0][Q_W-1:0]   quo_next;
        logic [DIVS_W-1:0]           dsh [NLANE];

        always_comb
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                dsh[l] = DIVS_W'(((l < 2) ? bs : side)) << K;
                quo_next[l] = quo_reg[i-1][l];
                if (DIVS_W'(rem_reg[i-1][l]) >= dsh[l])
                begin
                    rem_next[l]    = REM_W'(DIVS_W'(rem_reg[i-1][l]) - dsh[l]);
                    quo_next[l][K] = 1'b1;
                end
                else
                    rem_next[l] = rem_reg[i-1][l];
            end
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                rem_reg[i]     <= rem_next;
                quo_reg[i]     <= quo_next;
                outside_reg[i] <= outside_reg[i-1];
            end
        end
    end

    // Output stage
    logic [NLANE-1:0][Q_W-1:0] qf;
    logic                      parity;
    chan_t                     ch_next [NCHAN];

    assign qf     = quo_reg[DIV_STAGES];
    assign parity = qf[0][0] ^ qf[1][0];

    always_comb
    begin
        for (int k = 0; k < NCHAN; k++)
        begin
            if (outside_reg[DIV_STAGES])
                ch_next[k] = '0;
            else if (mode_reg == MODE_FLAT)
                ch_next[k] = color_a_reg[CH_W*k +: CH_W];
            else if (is_check)
                ch_next[k] = parity ? color_b_reg[CH_W*k +: CH_W]
                                    : color_a_reg[CH_W*k +: CH_W];
            else
                ch_next[k] = qf[k + 2][CH_W-1:0];
        end
    end

    chan_t out_ch0_reg;
    chan_t out_ch1_reg;
    chan_t out_ch2_reg;
    logic  out_outside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pipe_en)
            out_valid_reg <= valid_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            out_ch0_reg     <= ch_next[0];
            out_ch1_reg     <= ch_next[1];
            out_ch2_reg     <= ch_next[2];
            out_outside_reg <= outside_reg[DIV_STAGES];
        end
    end

    assign pix_out.valid   = out_valid_reg;
    assign pix_out.chan0   = out_ch0_reg;
    assign pix_out.chan1   = out_ch1_reg;
    assign pix_out.chan2   = out_ch2_reg;
    assign pix_out.outside = out_outside_reg;

    `TPPG_ASSERT_SAME(a_outside_zero, clk, rst_n, pix_out.valid && pix_out.outside, (pix_out.chan0 == '0) && (pix_out.chan1 == '0) && (pix_out.chan2 == '0))
    `TPPG_ASSERT_NEXT(a_stall_hold, clk, rst_n, !pipe_en, $stable(valid_reg) && $stable(a_valid_reg))
    `TPPG_ASSERT_NEXT(a_accept_enter, clk, rst_n, pix_in.valid && pix_in.ready, a_valid_reg)

endmodule

`default_nettype wire
